>>> hw/rtl/biphasic_pulse_burst_sequencer_unit_defines.svh
// assertion helpers for the checker file
`ifndef BIPHASIC_PULSE_BURST_SEQUENCER_UNIT_DEFINES_SVH
`define BIPHASIC_PULSE_BURST_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define BPBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define BPBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/bpbs_pkg.sv
`default_nettype none

package bpbs_pkg;

  // internal counter widths
  localparam int TIME_BITS  = 24;
  localparam int COUNT_BITS = 16;

  // register field widths
  localparam int PULSE_W  = 16;
  localparam int HALF_W   = 16;
  localparam int GAP_W    = 24;
  localparam int PERIOD_W = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // compare widths wide enough for both operands
  localparam int TCMP_W = (TIME_BITS > GAP_W) ? TIME_BITS : GAP_W;
  localparam int PCMP_W = (COUNT_BITS > PULSE_W) ? COUNT_BITS : PULSE_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PULSES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC   = 3'd4;

  // register reset values
  localparam logic [PULSE_W-1:0]  PULSES_RST = 16'd10;
  localparam logic [HALF_W-1:0]   HALF_RST   = 16'd1;
  localparam logic [GAP_W-1:0]    GAP_RST    = 24'd500;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 24'd33333;

  typedef enum logic [1:0] {
    PH_BURST1 = 2'd0,
    PH_GAP    = 2'd1,
    PH_BURST2 = 2'd2,
    PH_REST   = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t                phase;
    logic [TIME_BITS-1:0]  timer;
    logic [COUNT_BITS-1:0] count;
    logic                  neg;
    logic [TIME_BITS-1:0]  since2;
  } seq_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/biphasic_pulse_burst_sequencer_unit.sv
// output timing: a result item is valid in the cycle after its tick item is accepted
// throughput: one tick item per clock while out_stall does not hold the output; the path is the phase-skip chain of up
//   to four compares plus the timer and pulse-count update before the state flops
// reset (rst, synchronous): registers return to their defaults, the frame
//   restarts in the first burst with positive half, output register empty
`default_nettype none

module biphasic_pulse_burst_sequencer_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [bpbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bpbs_pkg::CFG_DATA_W-1:0]     cfg_data,
  // tick items in
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                run,
  // pin level items out
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     g1_pos,
  output logic                                     g1_neg,
  output logic                                     g2_pos,
  output logic                                     g2_neg,
  output logic [1:0]                               frame_phase
);

  localparam int TB = bpbs_pkg::TIME_BITS;
  localparam int CB = bpbs_pkg::COUNT_BITS;
  localparam int TW = bpbs_pkg::TCMP_W;
  localparam int PW = bpbs_pkg::PCMP_W;
  localparam logic [TB-1:0] TIME_MAX  = '1;
  localparam logic [CB-1:0] COUNT_MAX = '1;

  // configuration registers
  logic [bpbs_pkg::PULSE_W-1:0]  pulses_per_burst;
  logic [bpbs_pkg::HALF_W-1:0]   half_period_us;
  logic [bpbs_pkg::GAP_W-1:0]    group_gap_us;
  logic [bpbs_pkg::PERIOD_W-1:0] period_us;
  logic                          sync_mode;

  // frame state
  bpbs_pkg::seq_state_t state, state_next;

  // settled state and pin levels for this tick
  bpbs_pkg::seq_state_t cur;
  logic                 pin_g1, pin_g2;

  // effective limits after clamping
  logic [PW-1:0] pulses_lim;
  logic [TW-1:0] half_lim;
  logic [TW-1:0] period_lim;
  logic [TW-1:0] gap_lim;

  logic accept;

  // an item enters when the output register is free or being drained
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    if (PW'(pulses_per_burst) > PW'(COUNT_MAX)) begin
      pulses_lim = PW'(COUNT_MAX);
    end else begin
      pulses_lim = PW'(pulses_per_burst);
    end
    // zero half period or period acts as one tick
    half_lim   = (half_period_us == '0) ? TW'(1) : TW'(half_period_us);
    period_lim = (period_us == '0) ? TW'(1) : TW'(period_us);
    gap_lim    = TW'(group_gap_us);
  end

  // skip every phase whose length is already used up, at most one lap
  always_comb begin
    bpbs_pkg::phase_t nxt;
    logic             leave;
    cur = state;
    for (int i = 0; i < 4; i++) begin
      leave = 1'b0;
      nxt   = cur.phase;
      case (cur.phase)
        bpbs_pkg::PH_BURST1: begin
          if (PW'(cur.count) >= pulses_lim) begin
            leave = 1'b1;
            nxt   = sync_mode ? bpbs_pkg::PH_REST : bpbs_pkg::PH_GAP;
          end
        end
        bpbs_pkg::PH_GAP: begin
          if (TW'(cur.timer) >= gap_lim) begin
            leave = 1'b1;
            nxt   = bpbs_pkg::PH_BURST2;
          end
        end
        bpbs_pkg::PH_BURST2: begin
          if (PW'(cur.count) >= pulses_lim) begin
            leave = 1'b1;
            nxt   = bpbs_pkg::PH_REST;
          end
        end
        bpbs_pkg::PH_REST: begin
          // sync mode rests a full period; sequential counts from second burst start
          if (sync_mode ? (TW'(cur.timer) >= period_lim)
                        : (TW'(cur.since2) >= period_lim)) begin
            leave = 1'b1;
            nxt   = bpbs_pkg::PH_BURST1;
          end
        end
        default: begin
          leave = 1'b0;
        end
      endcase
      if (leave) begin
        cur.phase = nxt;
        cur.timer = '0;
        cur.count = '0;
        cur.neg   = 1'b0;
        if (nxt == bpbs_pkg::PH_BURST2) begin
          cur.since2 = '0;
        end
      end
    end
  end

  // which groups are driven this tick
  always_comb begin
    pin_g1 = (cur.phase == bpbs_pkg::PH_BURST1);
    pin_g2 = (cur.phase == bpbs_pkg::PH_BURST2) ||
             ((cur.phase == bpbs_pkg::PH_BURST1) && sync_mode);
  end

  // advance one microsecond from the settled state
  always_comb begin
    state_next = cur;
    if (cur.timer != TIME_MAX) begin
      state_next.timer = cur.timer + TB'(1);
    end
    if ((cur.phase == bpbs_pkg::PH_BURST2) || (cur.phase == bpbs_pkg::PH_REST)) begin
      if (cur.since2 != TIME_MAX) begin
        state_next.since2 = cur.since2 + TB'(1);
      end
    end
    // half period done: flip polarity, a full pulse counts on the way back
    if (((cur.phase == bpbs_pkg::PH_BURST1) || (cur.phase == bpbs_pkg::PH_BURST2)) &&
        (TW'(state_next.timer) >= half_lim)) begin
      state_next.timer = '0;
      state_next.neg   = ~cur.neg;
      if (cur.neg && (cur.count != COUNT_MAX)) begin
        state_next.count = cur.count + CB'(1);
      end
    end
    // run low restarts the frame
    if (!run) begin
      state_next = '0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_per_burst <= bpbs_pkg::PULSES_RST;
      half_period_us   <= bpbs_pkg::HALF_RST;
      group_gap_us     <= bpbs_pkg::GAP_RST;
      period_us        <= bpbs_pkg::PERIOD_RST;
      sync_mode        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        bpbs_pkg::REG_PULSES: pulses_per_burst <= cfg_data[bpbs_pkg::PULSE_W-1:0];
        bpbs_pkg::REG_HALF:   half_period_us   <= cfg_data[bpbs_pkg::HALF_W-1:0];
        bpbs_pkg::REG_GAP:    group_gap_us     <= cfg_data[bpbs_pkg::GAP_W-1:0];
        bpbs_pkg::REG_PERIOD: period_us        <= cfg_data[bpbs_pkg::PERIOD_W-1:0];
        bpbs_pkg::REG_SYNC:   sync_mode        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // frame state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      g1_pos      <= run & pin_g1 & ~cur.neg;
      g1_neg      <= run & pin_g1 & cur.neg;
      g2_pos      <= run & pin_g2 & ~cur.neg;
      g2_neg      <= run & pin_g2 & cur.neg;
      frame_phase <= run ? cur.phase : bpbs_pkg::PH_BURST1;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bpbs_checker.sv
`default_nettype none
`include "biphasic_pulse_burst_sequencer_unit_defines.svh"

module bpbs_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic                            run,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic                            g1_pos,
  input wire logic                            g1_neg,
  input wire logic                            g2_pos,
  input wire logic                            g2_neg,
  input wire logic [1:0]                      frame_phase
);

  // an accepted tick always yields an item next cycle
  `BPBS_ASSERT_NEXT(a_tick_gives_item, in_valid && !in_stall, out_valid, "missing result item")

  // a stopped tick leaves every pin low in the first phase
  `BPBS_ASSERT_NEXT(a_stop_clears, in_valid && !in_stall && !run,
    !g1_pos && !g1_neg && !g2_pos && !g2_neg && frame_phase == bpbs_pkg::PH_BURST1,
    "pins not cleared on stop")

  // gap and rest drive no pin, and group one is idle in the second burst
  `BPBS_ASSERT_NOW(a_idle_pins, out_valid && (frame_phase == bpbs_pkg::PH_GAP ||
    frame_phase == bpbs_pkg::PH_REST || frame_phase == bpbs_pkg::PH_BURST2),
    !g1_pos && !g1_neg && (frame_phase == bpbs_pkg::PH_BURST2 || (!g2_pos && !g2_neg)),
    "pin driven outside its burst")

  // both polarities of a group are never high together
  `BPBS_ASSERT_NOW(a_no_short, out_valid, !(g1_pos && g1_neg) && !(g2_pos && g2_neg),
    "both pins of a group high")

  // a stalled item holds
  `BPBS_ASSERT_NEXT(a_hold, out_valid && out_stall,
    out_valid && $stable(g1_pos) && $stable(g1_neg) && $stable(g2_pos) &&
    $stable(g2_neg) && $stable(frame_phase), "stalled item changed")

endmodule

bind biphasic_pulse_burst_sequencer_unit bpbs_checker u_bpbs_checker (.*);

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int QUIET_LIMIT = 1000;

  typedef struct {
    logic        run;
    int unsigned idle;
    bit          drain;
  } tick_item_t;

  typedef struct packed {
    logic             g1p;
    logic             g1n;
    logic             g2p;
    logic             g2n;
    bpbs_pkg::phase_t ph;
  } pin_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            cfg_we = 1'b0;
  logic [bpbs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bpbs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic run = 1'b0;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       g1_pos;
  logic       g1_neg;
  logic       g2_pos;
  logic       g2_neg;
  logic [1:0] frame_phase;

  // pending tick items and expected pin levels
  tick_item_t tick_q[$];
  pin_item_t  pin_q[$];

  int unsigned idle_left = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int          errors = 0;
  bit          steady_run = 1'b0;

  // shadow copy of the registers
  logic [bpbs_pkg::PULSE_W-1:0]  cfg_pulses;
  logic [bpbs_pkg::HALF_W-1:0]   cfg_half;
  logic [bpbs_pkg::GAP_W-1:0]    cfg_gap;
  logic [bpbs_pkg::PERIOD_W-1:0] cfg_period;
  logic                          cfg_sync;

  // sequencer state as the predictor sees it
  bpbs_pkg::phase_t                seq_phase;
  logic [bpbs_pkg::TIME_BITS-1:0]  ph_timer;
  logic [bpbs_pkg::COUNT_BITS-1:0] pulse_cnt;
  logic                            neg_half;
  logic [bpbs_pkg::TIME_BITS-1:0]  since2;

  biphasic_pulse_burst_sequencer_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .run        (run),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .g1_pos     (g1_pos),
    .g1_neg     (g1_neg),
    .g2_pos     (g2_pos),
    .g2_neg     (g2_neg),
    .frame_phase(frame_phase)
  );

  always #10 clk = ~clk;

  function automatic logic [bpbs_pkg::TIME_BITS-1:0] sat_tick(
      logic [bpbs_pkg::TIME_BITS-1:0] v);
    return (v == {bpbs_pkg::TIME_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic void enter_phase(bpbs_pkg::phase_t p);
    seq_phase = p;
    ph_timer  = '0;
    pulse_cnt = '0;
    neg_half  = 1'b0;
    if (p == bpbs_pkg::PH_BURST2) since2 = '0;
  endfunction

  // pin levels for one microsecond tick, and the state update it causes
  function automatic pin_item_t predict_pins(logic run_bit);
    pin_item_t                      r;
    logic [bpbs_pkg::HALF_W-1:0]    half;
    logic [bpbs_pkg::PERIOD_W-1:0]  period;
    logic [bpbs_pkg::TIME_BITS-1:0] rest_time;
    bit                             settled;
    bit                             g1;
    bit                             g2;
    int                             k;
    r.g1p = 1'b0;
    r.g1n = 1'b0;
    r.g2p = 1'b0;
    r.g2n = 1'b0;
    r.ph  = bpbs_pkg::PH_BURST1;
    if (!run_bit) begin
      // run low restarts the frame, registers are kept
      enter_phase(bpbs_pkg::PH_BURST1);
      since2 = '0;
      return r;
    end
    half   = (cfg_half == '0) ? bpbs_pkg::HALF_W'(1) : cfg_half;
    period = (cfg_period == '0) ? bpbs_pkg::PERIOD_W'(1) : cfg_period;
    // leave every phase whose length is already used up, at most four hops
    settled = 1'b0;
    for (k = 0; k < 4; k++) begin
      if (!settled) begin
        case (seq_phase)
          bpbs_pkg::PH_BURST1: begin
            if (pulse_cnt < cfg_pulses) settled = 1'b1;
            else enter_phase(cfg_sync ? bpbs_pkg::PH_REST : bpbs_pkg::PH_GAP);
          end
          bpbs_pkg::PH_GAP: begin
            if (ph_timer < cfg_gap) settled = 1'b1;
            else enter_phase(bpbs_pkg::PH_BURST2);
          end
          bpbs_pkg::PH_BURST2: begin
            if (pulse_cnt < cfg_pulses) settled = 1'b1;
            else enter_phase(bpbs_pkg::PH_REST);
          end
          default: begin
            rest_time = cfg_sync ? ph_timer : since2;
            if (rest_time < period) settled = 1'b1;
            else enter_phase(bpbs_pkg::PH_BURST1);
          end
        endcase
      end
    end
    g1 = (seq_phase == bpbs_pkg::PH_BURST1);
    g2 = (seq_phase == bpbs_pkg::PH_BURST2) || (g1 && cfg_sync);
    if (g1) begin
      r.g1p = !neg_half;
      r.g1n = neg_half;
    end
    if (g2) begin
      r.g2p = !neg_half;
      r.g2n = neg_half;
    end
    r.ph = seq_phase;
    ph_timer = sat_tick(ph_timer);
    if (seq_phase == bpbs_pkg::PH_BURST2 || seq_phase == bpbs_pkg::PH_REST) begin
      since2 = sat_tick(since2);
    end
    // end of a polarity half inside a burst
    if ((seq_phase == bpbs_pkg::PH_BURST1 || seq_phase == bpbs_pkg::PH_BURST2) &&
        ph_timer >= half) begin
      ph_timer = '0;
      if (neg_half) begin
        neg_half = 1'b0;
        if (pulse_cnt != {bpbs_pkg::COUNT_BITS{1'b1}}) pulse_cnt = pulse_cnt + 1'b1;
      end else begin
        neg_half = 1'b1;
      end
    end
    return r;
  endfunction

  // tick driver: holds a stalled item, waits out the drawn idle count after each
  // accepted item, and holds off items flagged to wait for all pin results
  always @(posedge clk) begin : tick_driver
    tick_item_t nxt;
    if (rst) begin
      in_valid  <= 1'b0;
      run       <= 1'b0;
      idle_left <= 0;
    end else begin
      if (in_valid && !in_stall) pin_q.push_back(predict_pins(run));
      if (in_valid && in_stall) begin
        // payload stays put while stalled
      end else if (idle_left > 0) begin
        in_valid  <= 1'b0;
        run       <= 1'($urandom_range(0, 1));
        idle_left <= idle_left - 1;
      end else if (tick_q.size() > 0 && !(tick_q[0].drain && pin_q.size() != 0)) begin
        nxt = tick_q.pop_front();
        in_valid  <= 1'b1;
        run       <= nxt.run;
        idle_left <= nxt.idle;
      end else begin
        in_valid <= 1'b0;
        run      <= 1'($urandom_range(0, 1));
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // pin monitor: compares each accepted result item, then draws its stall
  always @(posedge clk) begin : pin_monitor
    pin_item_t   want;
    int unsigned n;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pin_q.size() == 0) begin
          $error("result item with no expectation waiting");
          errors++;
        end else begin
          want = pin_q.pop_front();
          check_field("g1_pos", want.g1p, g1_pos);
          check_field("g1_neg", want.g1n, g1_neg);
          check_field("g2_pos", want.g2p, g2_pos);
          check_field("g2_neg", want.g2n, g2_neg);
          check_field("frame_phase", want.ph, frame_phase);
        end
        n = steady_run ? 0 : $urandom_range(0, 15);
        out_stall  <= (n != 0);
        stall_left <= (n != 0) ? n - 1 : 0;
      end else if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[biphasic_pulse_burst_sequencer_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_tick(logic run_bit, bit drain);
    tick_item_t t;
    t.run   = run_bit;
    t.idle  = steady_run ? 0 : $urandom_range(0, 15);
    t.drain = drain;
    tick_q.push_back(t);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (tick_q.size() != 0 || in_valid || pin_q.size() != 0);
  endtask

  task automatic write_reg(logic [bpbs_pkg::CFG_IDX_W-1:0] idx,
                           logic [bpbs_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      bpbs_pkg::REG_PULSES: cfg_pulses = data[bpbs_pkg::PULSE_W-1:0];
      bpbs_pkg::REG_HALF:   cfg_half   = data[bpbs_pkg::HALF_W-1:0];
      bpbs_pkg::REG_GAP:    cfg_gap    = data[bpbs_pkg::GAP_W-1:0];
      bpbs_pkg::REG_PERIOD: cfg_period = data[bpbs_pkg::PERIOD_W-1:0];
      bpbs_pkg::REG_SYNC:   cfg_sync   = data[0];
      default: ;
    endcase
  endtask

  // all five registers, with junk above the narrow fields
  task automatic set_config(logic [bpbs_pkg::PULSE_W-1:0] p,
                            logic [bpbs_pkg::HALF_W-1:0] h,
                            logic [bpbs_pkg::GAP_W-1:0] g,
                            logic [bpbs_pkg::PERIOD_W-1:0] per, logic s);
    logic [bpbs_pkg::CFG_DATA_W-1:0] junk;
    wait_idle();
    junk = bpbs_pkg::CFG_DATA_W'($urandom);
    write_reg(bpbs_pkg::REG_PULSES, {junk[bpbs_pkg::CFG_DATA_W-1:bpbs_pkg::PULSE_W], p});
    junk = bpbs_pkg::CFG_DATA_W'($urandom);
    write_reg(bpbs_pkg::REG_HALF, {junk[bpbs_pkg::CFG_DATA_W-1:bpbs_pkg::HALF_W], h});
    write_reg(bpbs_pkg::REG_GAP, g);
    write_reg(bpbs_pkg::REG_PERIOD, per);
    junk = bpbs_pkg::CFG_DATA_W'($urandom);
    write_reg(bpbs_pkg::REG_SYNC, {junk[bpbs_pkg::CFG_DATA_W-1:1], s});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [bpbs_pkg::PULSE_W-1:0]  p;
    logic [bpbs_pkg::HALF_W-1:0]   h;
    logic [bpbs_pkg::GAP_W-1:0]    g;
    logic [bpbs_pkg::PERIOD_W-1:0] per;
    logic                          s;
    int                            ph;
    int                            i;
    int                            k;

    cfg_pulses = bpbs_pkg::PULSES_RST;
    cfg_half   = bpbs_pkg::HALF_RST;
    cfg_gap    = bpbs_pkg::GAP_RST;
    cfg_period = bpbs_pkg::PERIOD_RST;
    cfg_sync   = 1'b0;
    enter_phase(bpbs_pkg::PH_BURST1);
    since2 = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset defaults, with one run-low restart in the middle of the burst
    for (i = 0; i < 12; i++) push_tick(i != 6, 1'b0);

    // every length zero: empty bursts and gap skipped, zero half and period act as one
    set_config('0, '0, '0, '0, 1'b0);
    for (i = 0; i < 4; i++) push_tick(1'b1, 1'b0);

    // synchronized mode with the shortest frame
    set_config(bpbs_pkg::PULSE_W'(1), '0, '0, bpbs_pkg::PERIOD_W'(1), 1'b1);
    for (i = 0; i < 4; i++) push_tick(1'b1, i == 2);

    // largest values everywhere
    set_config('1, '1, '1, '1, 1'b1);
    for (i = 0; i < 5; i++) push_tick(i != 3, 1'b0);

    // random phases: short frames so that every phase gets crossed many times
    for (ph = 0; ph < 14; ph++) begin
      p   = bpbs_pkg::PULSE_W'($urandom_range(0, 4));
      h   = bpbs_pkg::HALF_W'($urandom_range(0, 3));
      g   = bpbs_pkg::GAP_W'($urandom_range(0, 6));
      per = bpbs_pkg::PERIOD_W'($urandom_range(0, 40));
      s   = (ph < 2) ? ph[0] : 1'($urandom_range(0, 1));
      if (ph % 5 == 4) begin
        case ($urandom_range(0, 3))
          0: p = '1;
          1: h = '1;
          2: g = '1;
          default: per = '1;
        endcase
      end
      set_config(p, h, g, per, s);
      steady_run = (ph % 3 == 2);
      for (i = 0; i < 110; i++) begin
        if ($urandom_range(0, 59) == 0) begin
          // occasional stop, one to three ticks long
          for (k = $urandom_range(1, 3); k > 0; k--) push_tick(1'b0, 1'b0);
        end else begin
          push_tick(1'b1, i == 55 || $urandom_range(0, 79) == 0);
        end
      end
    end

    wait_idle();
    repeat (3) @(posedge clk);
    if (errors == 0) begin
      $display("[biphasic_pulse_burst_sequencer_unit] OK");
    end else begin
      $display("[biphasic_pulse_burst_sequencer_unit] ERROR");
    end
    $finish;
  end

endmodule
